[rtl/core/crp_pkg.sv]
package crp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_SAT_A  = 3'd0;
    localparam logic [2:0] REG_MIN_SAT_B  = 3'd1;
    localparam logic [2:0] REG_EXP_A      = 3'd2;
    localparam logic [2:0] REG_EXP_B      = 3'd3;
    localparam logic [2:0] REG_MAX_PERM_A = 3'd4;
    localparam logic [2:0] REG_MAX_PERM_B = 3'd5;

    localparam logic [16:0] Q_ONE = 17'd65536;

    // chain lengths and total latency in cycles
    localparam int DIV_CELLS = 32;
    localparam int LOG_CELLS = 32;
    localparam int EXP_CELLS = 32;
    localparam int LATENCY   = 1 + DIV_CELLS + 2 + LOG_CELLS + 3 + EXP_CELLS + 2;

    // how each phase result is formed
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_MAX,
        MODE_POW
    } crp_mode_t;

    typedef struct packed {
        logic                  valid;
        crp_mode_t [1:0]       mode;
    } crp_ctrl_t;

    // floor square root of a 64 bit value
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-(idx+1)) in Q0.32, by repeated floor square roots from 0.5
    function automatic logic [31:0] root_const(input int unsigned idx);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int unsigned k = 0; k <= idx; k++)
        begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage

[rtl/core/crp_div_cell.sv]
module crp_div_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] rem_in,
    input  logic [31:0] quo_in,
    input  logic [16:0] den_in,
    output logic [16:0] rem_out,
    output logic [31:0] quo_out,
    output logic [16:0] den_out
);
    logic [17:0] rem_shift;
    logic        ge;
    logic [17:0] rem_sub;
    logic [16:0] rem_next;

    // one restoring step, one quotient bit
    assign rem_shift = {rem_in, 1'b0};
    assign ge        = rem_shift >= {1'b0, den_in};
    assign rem_sub   = rem_shift - {1'b0, den_in};
    assign rem_next  = ge ? rem_sub[16:0] : rem_shift[16:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            quo_out <= {quo_in[30:0], ge};
            den_out <= den_in;
        end
    end
endmodule

[rtl/core/crp_log_cell.sv]
module crp_log_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] mant_in,
    input  logic [31:0] frac_in,
    input  logic [4:0]  top_in,
    output logic [31:0] mant_out,
    output logic [31:0] frac_out,
    output logic [4:0]  top_out
);
    logic [63:0] sq;
    logic [32:0] sq_q;
    logic        bit_set;

    // square the Q1.31 mantissa, one fraction bit of the log
    assign sq      = {32'd0, mant_in} * {32'd0, mant_in};
    assign sq_q    = sq[63:31];
    assign bit_set = sq_q[32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_out <= bit_set ? sq_q[32:1] : sq_q[31:0];
            frac_out <= {frac_in[30:0], bit_set};
            top_out  <= top_in;
        end
    end
endmodule

[rtl/core/crp_exp_cell.sv]
module crp_exp_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] root,
    input  logic [32:0] prod_in,
    input  logic [31:0] frac_in,
    input  logic [10:0] ip_in,
    output logic [32:0] prod_out,
    output logic [31:0] frac_out,
    output logic [10:0] ip_out
);
    logic [64:0] mul;

    // multiply in this cell's root factor when its fraction bit is set
    assign mul = {32'd0, prod_in} * {33'd0, root};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_out <= frac_in[31] ? mul[64:32] : prod_in;
            frac_out <= {frac_in[30:0], 1'b0};
            ip_out   <= ip_in;
        end
    end
endmodule

[rtl/core/corey_relative_permeability.sv]
// Corey relative permeability of two phases from one phase-b saturation, Q1.16 in and
// out. Fully pipelined: one beat per cycle in and out unless the output stalls, with three
// 32-cell chains per phase (quotient bits of the effective saturation, log2 fraction bits
// by squaring, exp2 factors by root multiplies). A stall on the output freezes the whole
// pipe; the user must hold configuration static while beats are in flight (not enforced).
module corey_relative_permeability (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [16:0] sat_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] perm_a,
    output logic [16:0] perm_b
);
    import crp_pkg::*;

    logic [16:0] min_sat_a_reg, min_sat_b_reg, max_perm_a_reg, max_perm_b_reg;
    logic [15:0] exp_a_reg, exp_b_reg;
    logic        en;
    crp_ctrl_t   ctrl_reg [LATENCY];
    logic [16:0] n_reg [2];
    logic [16:0] d_reg;
    logic [15:0] exp_sel [2];
    logic [16:0] kmax_sel [2];
    logic [16:0] perm_reg [2];

    logic signed [18:0] sb_s, sa_s, sbm_s, one_s, na_s, nb_s, d_s;
    logic               a_zero, b_low, b_high;
    crp_ctrl_t          ctrl_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sat_a_reg  <= '0;
            min_sat_b_reg  <= '0;
            exp_a_reg      <= 16'd8192;
            exp_b_reg      <= 16'd8192;
            max_perm_a_reg <= Q_ONE;
            max_perm_b_reg <= Q_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_SAT_A:  min_sat_a_reg  <= cfg_wr_data;
                REG_MIN_SAT_B:  min_sat_b_reg  <= cfg_wr_data;
                REG_EXP_A:      exp_a_reg      <= cfg_wr_data[15:0];
                REG_EXP_B:      exp_b_reg      <= cfg_wr_data[15:0];
                REG_MAX_PERM_A: max_perm_a_reg <= cfg_wr_data;
                REG_MAX_PERM_B: max_perm_b_reg <= cfg_wr_data;
                default:        ;
            endcase
        end
    end

    assign exp_sel[0]  = exp_a_reg;
    assign exp_sel[1]  = exp_b_reg;
    assign kmax_sel[0] = max_perm_a_reg;
    assign kmax_sel[1] = max_perm_b_reg;

    // global advance: the pipe moves unless the output beat is held
    assign en        = !ctrl_reg[LATENCY-1].valid || out_ready;
    assign in_ready  = en;
    assign out_valid = ctrl_reg[LATENCY-1].valid;
    assign perm_a    = perm_reg[0];
    assign perm_b    = perm_reg[1];

    // endpoint compares and numerators on exact signed values
    always_comb
    begin
        sb_s   = signed'({2'b00, sat_b});
        sa_s   = signed'({2'b00, min_sat_a_reg});
        sbm_s  = signed'({2'b00, min_sat_b_reg});
        one_s  = signed'({2'b00, Q_ONE});
        na_s   = one_s - sa_s - sb_s;
        nb_s   = sb_s - sbm_s;
        d_s    = one_s - sa_s - sbm_s;
        a_zero = (one_s - sb_s) <= sa_s;
        b_low  = sb_s <= sbm_s;
        b_high = sb_s >= (one_s - sa_s);
        ctrl_next.valid = in_valid;
        if (a_zero)
            ctrl_next.mode[0] = MODE_ZERO;
        else if (b_low)
            ctrl_next.mode[0] = MODE_MAX;
        else
            ctrl_next.mode[0] = MODE_POW;
        if (b_low)
            ctrl_next.mode[1] = MODE_ZERO;
        else if (b_high)
            ctrl_next.mode[1] = MODE_MAX;
        else
            ctrl_next.mode[1] = MODE_POW;
    end

    // control shift line alongside the data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctrl_reg[0] <= ctrl_next;
            for (int k = 1; k < LATENCY; k++)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= na_s[16:0];
            n_reg[1] <= nb_s[16:0];
            d_reg    <= d_s[16:0];
        end
    end

    for (genvar ph = 0; ph < 2; ph++)
    begin : g_lane
        logic [16:0] rem_c [DIV_CELLS+1];
        logic [31:0] quo_c [DIV_CELLS+1];
        logic [16:0] den_c [DIV_CELLS+1];
        logic [31:0] mant_c [LOG_CELLS+1];
        logic [31:0] frac_c [LOG_CELLS+1];
        logic [4:0]  top_c [LOG_CELLS+1];
        logic [32:0] prod_c [EXP_CELLS+1];
        logic [31:0] f_c [EXP_CELLS+1];
        logic [10:0] ip_c [EXP_CELLS+1];
        logic [31:0] x_reg;
        logic [4:0]  top_reg, top_next, top_m_reg;
        logic [31:0] m_reg;
        logic [5:0]  int_part;
        logic [37:0] negl_reg;
        logic [53:0] prod_e_reg;
        logic [54:0] round_sum;
        logic [42:0] y_reg;
        logic [49:0] kp_reg;
        logic [10:0] ipf_reg;
        logic [5:0]  shamt;
        logic [63:0] final_sum;
        logic [63:0] final_shift;
        logic [16:0] pow_res;
        logic [16:0] sel_res;

        // quotient chain: floor(n * 2^32 / d)
        assign rem_c[0] = n_reg[ph];
        assign quo_c[0] = '0;
        assign den_c[0] = d_reg;
        for (genvar j = 0; j < DIV_CELLS; j++)
        begin : g_div
            crp_div_cell u_div (
                .clk     (clk),
                .en      (en),
                .rem_in  (rem_c[j]),
                .quo_in  (quo_c[j]),
                .den_in  (den_c[j]),
                .rem_out (rem_c[j+1]),
                .quo_out (quo_c[j+1]),
                .den_out (den_c[j+1])
            );
        end

        // leading one position
        always_comb
        begin
            top_next = '0;
            for (int i = 0; i < 32; i++)
            begin
                if (quo_c[DIV_CELLS][i])
                    top_next = 5'(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg     <= quo_c[DIV_CELLS];
                top_reg   <= top_next;
                m_reg     <= x_reg << (5'd31 - top_reg);
                top_m_reg <= top_reg;
            end
        end

        // log2 fraction chain
        assign mant_c[0] = m_reg;
        assign frac_c[0] = '0;
        assign top_c[0]  = top_m_reg;
        for (genvar j = 0; j < LOG_CELLS; j++)
        begin : g_log
            crp_log_cell u_log (
                .clk      (clk),
                .en       (en),
                .mant_in  (mant_c[j]),
                .frac_in  (frac_c[j]),
                .top_in   (top_c[j]),
                .mant_out (mant_c[j+1]),
                .frac_out (frac_c[j+1]),
                .top_out  (top_c[j+1])
            );
        end

        // negative log, scale by exponent, round
        assign int_part  = 6'd32 - {1'b0, top_c[LOG_CELLS]};
        assign round_sum = {1'b0, prod_e_reg} + 55'd2048;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                negl_reg   <= {int_part, 32'd0} - {6'd0, frac_c[LOG_CELLS]};
                prod_e_reg <= {16'd0, negl_reg} * {38'd0, exp_sel[ph]};
                y_reg      <= round_sum[54:12];
            end
        end

        // exp2 of the fraction by root factors
        assign prod_c[0] = {1'b1, 32'd0};
        assign f_c[0]    = y_reg[31:0];
        assign ip_c[0]   = y_reg[42:32];
        for (genvar j = 0; j < EXP_CELLS; j++)
        begin : g_exp
            localparam logic [31:0] ROOT = root_const(j);
            crp_exp_cell u_exp (
                .clk      (clk),
                .en       (en),
                .root     (ROOT),
                .prod_in  (prod_c[j]),
                .frac_in  (f_c[j]),
                .ip_in    (ip_c[j]),
                .prod_out (prod_c[j+1]),
                .frac_out (f_c[j+1]),
                .ip_out   (ip_c[j+1])
            );
        end

        // endpoint scale, rounding shift and endpoint select
        assign shamt       = 6'd32 + {1'b0, ipf_reg[4:0]};
        assign final_sum   = {14'd0, kp_reg} + (64'd1 << (shamt - 6'd1));
        assign final_shift = final_sum >> shamt;
        assign pow_res     = (ipf_reg > 11'd28) ? 17'd0 : final_shift[16:0];

        always_comb
        begin
            unique case (ctrl_reg[LATENCY-2].mode[ph])
                MODE_ZERO: sel_res = '0;
                MODE_MAX:  sel_res = kmax_sel[ph];
                MODE_POW:  sel_res = pow_res;
                default:   sel_res = '0;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kp_reg       <= {33'd0, kmax_sel[ph]} * {17'd0, prod_c[EXP_CELLS]};
                ipf_reg      <= ip_c[EXP_CELLS];
                perm_reg[ph] <= sel_res;
            end
        end
    end

    // a result never exceeds its endpoint
    a_perm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (perm_a <= max_perm_a_reg) && (perm_b <= max_perm_b_reg))
        else $error("permeability above endpoint");

    // the input side only waits on a held output beat
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // phase b immobile gives zero phase b permeability
    a_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ctrl_reg[LATENCY-1].mode[1] == MODE_ZERO |-> perm_b == 17'd0)
        else $error("immobile phase b with nonzero permeability");

endmodule

[tb/corey_relative_permeability_tb.sv]
`timescale 1ns / 1ps

module corey_relative_permeability_tb;
    import crp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [16:0] sat_b;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] perm_a;
    logic [16:0] perm_b;

    typedef struct packed {
        logic [16:0] pa;
        logic [16:0] pb;
    } perm_pair_t;

    // model copy of the registers
    logic [16:0] m_min_a, m_min_b, m_kmax_a, m_kmax_b;
    logic [15:0] m_exp_a, m_exp_b;

    logic [16:0] sat_queue[$];
    perm_pair_t  perm_expected[$];
    int          mismatch_count;
    bit          hold_long;
    bit          rx_hold_done = 1'b0;
    bit          in_ready_seen;
    int          tx_gap = 0;
    int          rx_gap = 0;

    corey_relative_permeability dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sat_b      (sat_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .perm_a     (perm_a),
        .perm_b     (perm_b)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v && b != 0)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // kmax * (n/d)^e via log2 then exp2
    function automatic logic [63:0] corey_power(input logic [63:0] n, input logic [63:0] d,
                                                input logic [63:0] e, input logic [63:0] kmax);
        logic [63:0] x, m, frac, negl, y, ip, f, c, p, s;
        int top;
        x = (n << 32) / d;
        top = 31;
        while (top > 0 && x[top] == 1'b0)
            top--;
        m = x << (31 - top);
        frac = 0;
        for (int i = 31; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        negl = (64'(32 - top) << 32) - frac;
        y = (negl * e + 64'd2048) >> 12;
        ip = y >> 32;
        f = y & 64'hFFFF_FFFF;
        p = 64'd1 << 32;
        c = 64'd1 << 31;
        for (int i = 31; i >= 0; i--)
        begin
            c = floor_sqrt(c << 32);
            if (f[i])
                p = (p * c) >> 32;
        end
        if (ip > 28)
            return 0;
        s = 32 + ip;
        return (kmax * p + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic perm_pair_t predict_perms(input logic [16:0] sb_in);
        longint sb, sa_min, sb_min, den;
        logic [63:0] ka, kb;
        perm_pair_t r;
        sb = sb_in;
        sa_min = m_min_a;
        sb_min = m_min_b;
        den = 65536 - sa_min - sb_min;
        if (65536 - sb <= sa_min)
            ka = 0;
        else if (sb <= sb_min)
            ka = m_kmax_a;
        else
            ka = corey_power(65536 - sa_min - sb, den, m_exp_a, m_kmax_a);
        if (sb <= sb_min)
            kb = 0;
        else if (sb >= 65536 - sa_min)
            kb = m_kmax_b;
        else
            kb = corey_power(sb - sb_min, den, m_exp_b, m_kmax_b);
        r.pa = ka[16:0];
        r.pb = kb[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("%0t %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_MIN_SAT_A:  m_min_a  = val;
            REG_MIN_SAT_B:  m_min_b  = val;
            REG_EXP_A:      m_exp_a  = val[15:0];
            REG_EXP_B:      m_exp_b  = val[15:0];
            REG_MAX_PERM_A: m_kmax_a = val;
            REG_MAX_PERM_B: m_kmax_b = val;
            default: ;
        endcase
    endtask

    task automatic push_sat(input logic [16:0] v);
        sat_queue.push_back(v);
    endtask

    // random saturation, mostly inside the mobile range
    function automatic logic [16:0] random_sat();
        int unsigned lo, hi;
        lo = m_min_b;
        hi = (m_min_a > 65536) ? 0 : 65536 - m_min_a;
        case ($urandom_range(0, 9))
            0: return 17'($urandom);
            1: return 17'($urandom_range(0, 65536));
            2: return 17'(lo);
            3: return 17'(hi);
            default:
            begin
                if (hi > lo)
                    return 17'($urandom_range(lo, hi));
                return 17'($urandom_range(0, 65536));
            end
        endcase
    endfunction

    // wait until nothing is pending, sent or in flight
    task automatic wait_drained();
        do
            @(posedge clk);
        while (sat_queue.size() != 0 || in_valid || out_valid || perm_expected.size() != 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // accepted input beats and their predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready_seen <= 1'b0;
        end
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                perm_expected.push_back(predict_perms(sat_b));
            end
        end
    end

    // driver: one beat per pending saturation, random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_ready_seen))
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (sat_queue.size() > 0)
            begin
                sat_b    <= sat_queue.pop_front();
                in_valid <= 1'b1;
                tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_long && !rx_hold_done)
            begin
                out_ready <= 1'b0;
                rx_gap++;
                if (rx_gap >= 1000)
                begin
                    rx_hold_done = 1'b1;
                    rx_gap = 0;
                end
            end
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        perm_pair_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (perm_expected.size() == 0)
            begin
                report_mismatch("unexpected beat perm_a", perm_a, 17'd0);
            end
            else
            begin
                w = perm_expected.pop_front();
                if (perm_a !== w.pa)
                    report_mismatch("perm_a", perm_a, w.pa);
                if (perm_b !== w.pb)
                    report_mismatch("perm_b", perm_b, w.pb);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("corey_relative_permeability: mismatch");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MIN_SAT_A;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        sat_b = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        hold_long = 1'b0;
        m_min_a = 0;
        m_min_b = 0;
        m_exp_a = 16'd8192;
        m_exp_b = 16'd8192;
        m_kmax_a = 17'd65536;
        m_kmax_b = 17'd65536;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: field extremes and each bit
        push_sat(0);
        push_sat(1);
        push_sat(65535);
        push_sat(65536);
        push_sat(17'h1FFFF);
        push_sat(32768);
        for (int i = 0; i < 17; i++)
            push_sat(17'(1) << i);
        wait_drained();

        // residuals, zero exponent on a, steep exponent on b
        write_reg(REG_MIN_SAT_A, 17'd6554);
        write_reg(REG_MIN_SAT_B, 17'd13107);
        write_reg(REG_EXP_A, 17'd0);
        write_reg(REG_EXP_B, 17'd65535);
        write_reg(REG_MAX_PERM_A, 17'd40000);
        write_reg(REG_MAX_PERM_B, 17'd0);
        push_sat(13107);
        push_sat(13108);
        push_sat(58982);
        push_sat(58981);
        push_sat(30000);
        push_sat(0);
        wait_drained();

        // random phases, several settings including extremes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_MIN_SAT_A, 0);
                    write_reg(REG_MIN_SAT_B, 0);
                    write_reg(REG_EXP_A, 17'd4096);
                    write_reg(REG_EXP_B, 17'd12288);
                    write_reg(REG_MAX_PERM_A, 17'd65536);
                    write_reg(REG_MAX_PERM_B, 17'd65536);
                end
                1:
                begin
                    write_reg(REG_MIN_SAT_A, 17'd65536);
                    write_reg(REG_MIN_SAT_B, 17'd65536);
                    write_reg(REG_EXP_A, 17'd1);
                    write_reg(REG_EXP_B, 17'd65535);
                end
                2:
                begin
                    write_reg(REG_MIN_SAT_A, 17'h1FFFF);
                    write_reg(REG_MIN_SAT_B, 17'h1FFFF);
                    write_reg(REG_MAX_PERM_A, 17'h1FFFF);
                    write_reg(REG_MAX_PERM_B, 17'h1FFFF);
                end
                default:
                begin
                    write_reg(REG_MIN_SAT_A, 17'($urandom_range(0, 26000)));
                    write_reg(REG_MIN_SAT_B, 17'($urandom_range(0, 26000)));
                    write_reg(REG_EXP_A, 17'($urandom_range(0, 65535)));
                    write_reg(REG_EXP_B, 17'($urandom_range(0, 32768)));
                    write_reg(REG_MAX_PERM_A, 17'($urandom_range(0, 65536)));
                    write_reg(REG_MAX_PERM_B, 17'($urandom_range(0, 65536)));
                end
            endcase
            if (ph == 4)
                hold_long = 1'b1;
            for (int k = 0; k < 115; k++)
                push_sat(random_sat());
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("corey_relative_permeability: match");
        else
            $display("corey_relative_permeability: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/crp_pkg.sv
rtl/core/crp_div_cell.sv
rtl/core/crp_log_cell.sv
rtl/core/crp_exp_cell.sv
rtl/core/corey_relative_permeability.sv
tb/corey_relative_permeability_tb.sv
